// File: rtl/core/erm_pkg.sv
package erm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int SERIES_TERMS = 15;
    localparam int Q30_W = 31;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    typedef struct packed {
        logic [30:0] x;
        logic [30:0] term;
        logic signed [32:0] sn;
        logic signed [32:0] cs;
        logic [1:0] quad;
    } erm_cell_t;

    typedef struct packed {
        erm_cell_t cx;
        erm_cell_t cy;
        erm_cell_t cz;
    } erm_lane_t;

    function automatic logic [30:0] erm_clamp(input logic signed [32:0] v);
        logic [30:0] r;
        begin
            if (v < 0)
            begin
                r = '0;
            end
            else if (v > $signed({2'b00, Q30_ONE}))
            begin
                r = Q30_ONE;
            end
            else
            begin
                r = v[30:0];
            end
            return r;
        end
    endfunction

endpackage

// File: rtl/core/erm_cell.sv
module erm_cell
    import erm_pkg::*;
#(
    parameter int N = 1
)
(
    input  logic      clk,
    input  erm_cell_t din,
    output erm_cell_t dout
);

    localparam int RS = 32 + $clog2(N);
    localparam logic [32:0] RECIP = 33'(((65'd1 << RS) + 65'(N) - 65'd1) / 65'(N));

    erm_cell_t mid_reg;
    logic [31:0] shifted_reg;
    logic [31:0] shifted_next;
    erm_cell_t out_reg;
    erm_cell_t out_next;
    logic [61:0] prod;
    logic [64:0] quot;
    logic [30:0] t;

    always_comb
    begin
        prod = 62'(din.term) * 62'(din.x);
        shifted_next = prod[61:30];
    end

    // divide by N through a reciprocal multiply, exact for a 32-bit dividend
    always_comb
    begin
        quot = 65'(shifted_reg) * 65'(RECIP);
        t = 31'(quot >> RS);
        out_next = mid_reg;
        out_next.term = t;
        if ((N % 2) == 1)
        begin
            if (((N / 2) % 2) == 1)
            begin
                out_next.sn = mid_reg.sn - $signed({2'b00, t});
            end
            else
            begin
                out_next.sn = mid_reg.sn + $signed({2'b00, t});
            end
        end
        else
        begin
            if (((N / 2) % 2) == 1)
            begin
                out_next.cs = mid_reg.cs - $signed({2'b00, t});
            end
            else
            begin
                out_next.cs = mid_reg.cs + $signed({2'b00, t});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= din;
        shifted_reg <= shifted_next;
        out_reg <= out_next;
    end

    assign dout = out_reg;

endmodule

// File: rtl/core/erm_combine.sv
module erm_combine
    import erm_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  erm_lane_t din,
    output logic signed [OUT_FRAC_BITS+1:0] r [9]
);

    localparam int OW = OUT_FRAC_BITS + 2;
    localparam int SH = 60 - OUT_FRAC_BITS;

    logic signed [31:0] sx, cx, sy, cy, sz, cz;
    logic signed [31:0] s1x_reg, c1x_reg, s1y_reg, c1y_reg, s1z_reg, c1z_reg;
    logic signed [31:0] s2x_reg, c2x_reg, s2y_reg, c2y_reg, s2z_reg, c2z_reg;
    logic signed [31:0] szsy_reg, czsy_reg;
    logic signed [63:0] p_reg [11];
    logic signed [63:0] prods [11];
    logic signed [63:0] p2_reg [6];
    logic signed [64:0] e [9];
    logic signed [OW-1:0] r_reg [9];

    function automatic logic signed [31:0] rnd30(input logic signed [63:0] v);
        logic signed [63:0] t;
        begin
            t = v + 64'sd536870912;
            return 32'(t >>> 30);
        end
    endfunction

    function automatic logic signed [OW-1:0] to_out(input logic signed [64:0] v);
        logic signed [64:0] t;
        logic signed [64:0] lim;
        begin
            t = (v + (65'sd1 <<< (SH - 1))) >>> SH;
            lim = 65'sd1 <<< OUT_FRAC_BITS;
            if (t > lim)
            begin
                t = lim;
            end
            if (t < -lim)
            begin
                t = -lim;
            end
            return OW'(t);
        end
    endfunction

    function automatic void fold(input erm_cell_t c, output logic signed [31:0] s,
        output logic signed [31:0] co);
        logic signed [31:0] sv, cv;
        begin
            sv = $signed({1'b0, erm_clamp(c.sn)});
            cv = $signed({1'b0, erm_clamp(c.cs)});
            unique case (c.quad)
                2'd0:
                begin
                    s = sv; co = cv;
                end
                2'd1:
                begin
                    s = cv; co = -sv;
                end
                2'd2:
                begin
                    s = -sv; co = -cv;
                end
                default:
                begin
                    s = -cv; co = sv;
                end
            endcase
        end
    endfunction

    always_comb
    begin
        fold(din.cx, sx, cx);
        fold(din.cy, sy, cy);
        fold(din.cz, sz, cz);
    end

    always_comb
    begin
        prods[0] = 64'(s1z_reg) * 64'(s1y_reg);
        prods[1] = 64'(c1z_reg) * 64'(s1y_reg);
        prods[2] = 64'(c1y_reg) * 64'(c1x_reg);
        prods[3] = 64'(c1y_reg) * 64'(s1x_reg);
        prods[4] = 64'(s1y_reg) <<< 30;
        prods[5] = 64'(c1z_reg) * 64'(s1x_reg);
        prods[6] = 64'(c1z_reg) * 64'(c1x_reg);
        prods[7] = 64'(c1y_reg) * 64'(s1z_reg);
        prods[8] = 64'(s1z_reg) * 64'(s1x_reg);
        prods[9] = 64'(c1x_reg) * 64'(s1z_reg);
        prods[10] = 64'(c1z_reg) * 64'(c1y_reg);
    end

    always_ff @(posedge clk)
    begin
        s1x_reg <= sx; c1x_reg <= cx; s1y_reg <= sy;
        c1y_reg <= cy; s1z_reg <= sz; c1z_reg <= cz;
        p_reg <= prods;
        s2x_reg <= s1x_reg; c2x_reg <= c1x_reg; s2y_reg <= s1y_reg;
        c2y_reg <= c1y_reg; s2z_reg <= s1z_reg; c2z_reg <= c1z_reg;
        szsy_reg <= rnd30(prods[0]);
        czsy_reg <= rnd30(prods[1]);
    end

    logic signed [63:0] p1_reg [11];

    always_ff @(posedge clk)
    begin
        p1_reg <= p_reg;
        p2_reg[0] <= 64'(c2x_reg) * 64'(szsy_reg);
        p2_reg[1] <= 64'(s2x_reg) * 64'(szsy_reg);
        p2_reg[2] <= 64'(c2x_reg) * 64'(czsy_reg);
        p2_reg[3] <= 64'(s2x_reg) * 64'(czsy_reg);
        p2_reg[4] <= '0;
        p2_reg[5] <= '0;
    end

    always_comb
    begin
        e[0] = 65'(p1_reg[2]);
        e[1] = -65'(p1_reg[3]);
        e[2] = 65'(p1_reg[4]);
        e[3] = 65'(p1_reg[5]) + 65'(p2_reg[0]);
        e[4] = 65'(p1_reg[6]) - 65'(p2_reg[1]);
        e[5] = -65'(p1_reg[7]);
        e[6] = 65'(p1_reg[8]) - 65'(p2_reg[2]);
        e[7] = 65'(p1_reg[9]) + 65'(p2_reg[3]) + 65'(p2_reg[4]) + 65'(p2_reg[5]);
        e[8] = 65'(p1_reg[10]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            r_reg[i] <= to_out(e[i]);
        end
    end

    assign r = r_reg;

endmodule

// File: rtl/core/euler_rotation_matrix.sv
// Throughput: one word per cycle; each angle runs down a chain of 15 series cells,
// one Taylor term per cell in two stages, then a product and rounding pipe.
// busy stays low; the receiver cannot stall and takes each word when strobe is high.
// Reset clears the valid chain only; data registers are not reset.
module euler_rotation_matrix
    import erm_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic [15:0] angle_x,
    input  logic [15:0] angle_y,
    input  logic [15:0] angle_z,
    output logic strobe,
    output logic signed [OUT_FRAC_BITS+1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22
);

    localparam int LAT = 2 * SERIES_TERMS + 5;

    erm_lane_t seed_reg;
    erm_lane_t chain [SERIES_TERMS+1];
    logic signed [OUT_FRAC_BITS+1:0] r [9];
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    function automatic erm_cell_t seed(input logic [15:0] ang);
        logic [ANGLE_BITS-1:0] a;
        logic [31:0] u;
        logic [63:0] p;
        erm_cell_t c;
        begin
            a = ANGLE_BITS'(ang);
            u = {a[ANGLE_BITS-3:0], {(34 - ANGLE_BITS){1'b0}}};
            p = 64'(u) * 64'(HALF_PI_Q30);
            c.x = p[62:32];
            c.term = Q30_ONE;
            c.sn = '0;
            c.cs = $signed({2'b00, Q30_ONE});
            c.quad = a[ANGLE_BITS-1:ANGLE_BITS-2];
            return c;
        end
    endfunction

    always_ff @(posedge clk)
    begin
        seed_reg.cx <= seed(angle_x);
        seed_reg.cy <= seed(angle_y);
        seed_reg.cz <= seed(angle_z);
    end

    assign chain[0] = seed_reg;

    for (genvar i = 0; i < SERIES_TERMS; i++)
    begin : g_cell
        erm_cell #(.N(i + 1)) u_x (.clk(clk), .din(chain[i].cx), .dout(chain[i+1].cx));
        erm_cell #(.N(i + 1)) u_y (.clk(clk), .din(chain[i].cy), .dout(chain[i+1].cy));
        erm_cell #(.N(i + 1)) u_z (.clk(clk), .din(chain[i].cz), .dout(chain[i+1].cz));
    end

    erm_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_comb
    (
        .clk(clk),
        .din(chain[SERIES_TERMS]),
        .r(r)
    );

    assign vld_next = {vld_reg[LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign busy = 1'b0;
    assign strobe = vld_reg[LAT-1];
    assign r00 = r[0];
    assign r01 = r[1];
    assign r02 = r[2];
    assign r10 = r[3];
    assign r11 = r[4];
    assign r12 = r[5];
    assign r20 = r[6];
    assign r21 = r[7];
    assign r22 = r[8];

endmodule

// File: rtl/core/erm_checker.sv
module erm_checker
    import erm_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic strobe,
    input logic signed [OUT_FRAC_BITS+1:0] r00,
    input logic signed [OUT_FRAC_BITS+1:0] r22
);

    localparam int LAT = 2 * SERIES_TERMS + 5;
    localparam logic signed [OUT_FRAC_BITS+1:0] ONE = (OUT_FRAC_BITS+2)'(1 <<< OUT_FRAC_BITS);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT strobe)
        else $error("word not delivered after pipeline latency");

    a_r00: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (r00 <= ONE && r00 >= -ONE))
        else $error("r00 out of range");

    a_r22: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (r22 <= ONE && r22 >= -ONE))
        else $error("r22 out of range");

endmodule

bind euler_rotation_matrix erm_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_erm_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .strobe(strobe),
    .r00(r00),
    .r22(r22)
);

// File: sim/euler_rotation_matrix_tb.sv
module euler_rotation_matrix_tb;
    import erm_pkg::*;

    localparam int AB = 16;
    localparam int OFB = 14;
    localparam int OW = OFB + 2;
    localparam int LATENCY = 2 * SERIES_TERMS + 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint ONE_Q30 = 64'sd1 << 30;

    typedef struct packed {
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
    } angles_t;

    typedef logic signed [OW-1:0] entry_t;

    typedef struct packed {
        entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
    } matrix_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [15:0] angle_x, angle_y, angle_z;
    logic strobe;
    entry_t r00, r01, r02, r10, r11, r12, r20, r21, r22;

    angles_t pending_angles[$];
    matrix_t expected_matrices[$];
    int errors = 0;
    int words_sent = 0;
    int words_seen = 0;
    int cycles = 0;
    int quiet_after = 0;
    int gap_left = 0;

    euler_rotation_matrix dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
        .strobe(strobe),
        .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
        .r20(r20), .r21(r21), .r22(r22)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint round_half_up(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v < 0)
        begin
            return 0;
        end
        if (v > ONE_Q30)
        begin
            return ONE_Q30;
        end
        return v;
    endfunction

    function automatic void sine_cosine(input logic [15:0] ang, output longint s,
        output longint c);
        logic [1:0] quad;
        longint unsigned frac, x, term;
        longint sn, cs, ss, cc;
        quad = ang[AB-1 -: 2];
        frac = 64'(ang[AB-3:0]) << (32 - (AB - 2));
        x = (frac * 64'd1686629713) >> 32;
        term = ONE_Q30;
        sn = 0;
        cs = ONE_Q30;
        for (int n = 1; n <= SERIES_TERMS; n++)
        begin
            term = ((term * x) >> 30) / n;
            if (n % 2 == 1)
            begin
                if ((n & 2) != 0) sn -= longint'(term); else sn += longint'(term);
            end
            else
            begin
                if ((n & 2) != 0) cs -= longint'(term); else cs += longint'(term);
            end
        end
        ss = unit_clamp(sn);
        cc = unit_clamp(cs);
        case (quad)
            2'd0: begin s = ss; c = cc; end
            2'd1: begin s = cc; c = -ss; end
            2'd2: begin s = -ss; c = -cc; end
            default: begin s = -cc; c = ss; end
        endcase
    endfunction

    function automatic entry_t q60_to_entry(longint v);
        longint r;
        longint lim;
        lim = 64'sd1 <<< OFB;
        r = round_half_up(v, 60 - OFB);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return entry_t'(r);
    endfunction

    function automatic matrix_t rotation_of(angles_t a);
        longint sx, cx, sy, cy, sz, cz, szsy, czsy;
        matrix_t m;
        sine_cosine(a.ax, sx, cx);
        sine_cosine(a.ay, sy, cy);
        sine_cosine(a.az, sz, cz);
        szsy = round_half_up(sz * sy, 30);
        czsy = round_half_up(cz * sy, 30);
        m.m00 = q60_to_entry(cy * cx);
        m.m01 = q60_to_entry(-(cy * sx));
        m.m02 = q60_to_entry(sy * ONE_Q30);
        m.m10 = q60_to_entry(cz * sx + cx * szsy);
        m.m11 = q60_to_entry(cz * cx - sx * szsy);
        m.m12 = q60_to_entry(-(cy * sz));
        m.m20 = q60_to_entry(sz * sx - cx * czsy);
        m.m21 = q60_to_entry(cx * sz + sx * czsy);
        m.m22 = q60_to_entry(cz * cy);
        return m;
    endfunction

    task automatic report_mismatch(string field, entry_t got, entry_t want);
        errors++;
        $display("mismatch word %0d %s: got %0d expected %0d", words_seen, field, got, want);
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 3)) << 14;
            1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 4)) - 16'd2;
            2: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        angles_t a;
        logic [15:0] corners[6];
        corners = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h3fff};
        for (int i = 0; i < 6; i++)
        begin
            pending_angles.push_back('{corners[i], corners[(i + 1) % 6], corners[(i + 3) % 6]});
        end
        pending_angles.push_back('{16'h2000, 16'h6000, 16'ha000});
        pending_angles.push_back('{16'h5555, 16'haaaa, 16'h1234});
        pending_angles.push_back('{16'h0001, 16'h7fff, 16'h8001});
        for (int i = 0; i < 1100; i++)
        begin
            a.ax = pick_angle();
            a.ay = pick_angle();
            a.az = pick_angle();
            pending_angles.push_back(a);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        angle_x = '0;
        angle_y = '0;
        angle_z = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                void'(pending_angles.pop_front());
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_angles.size() > 0 && pending_angles.size() > 150
                     && $urandom_range(0, 19) == 0)
            begin
                gap_left <= $urandom_range(0, 13);
                start <= 1'b0;
            end
            else if (pending_angles.size() > 0 && !(start && !busy && pending_angles.size() == 0))
            begin
                start <= 1'b1;
                angle_x <= pending_angles[0].ax;
                angle_y <= pending_angles[0].ay;
                angle_z <= pending_angles[0].az;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        matrix_t want;
        angles_t sent;
        cycles <= cycles + 1;
        if (rst_n && start && !busy)
        begin
            sent = '{angle_x, angle_y, angle_z};
            expected_matrices.push_back(rotation_of(sent));
            words_sent <= words_sent + 1;
        end
        if (rst_n && strobe)
        begin
            words_seen <= words_seen + 1;
            if (expected_matrices.size() == 0)
            begin
                errors++;
                $display("unexpected word at cycle %0d", cycles);
            end
            else
            begin
                want = expected_matrices.pop_front();
                if (r00 !== want.m00) report_mismatch("r00", r00, want.m00);
                if (r01 !== want.m01) report_mismatch("r01", r01, want.m01);
                if (r02 !== want.m02) report_mismatch("r02", r02, want.m02);
                if (r10 !== want.m10) report_mismatch("r10", r10, want.m10);
                if (r11 !== want.m11) report_mismatch("r11", r11, want.m11);
                if (r12 !== want.m12) report_mismatch("r12", r12, want.m12);
                if (r20 !== want.m20) report_mismatch("r20", r20, want.m20);
                if (r21 !== want.m21) report_mismatch("r21", r21, want.m21);
                if (r22 !== want.m22) report_mismatch("r22", r22, want.m22);
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while ((pending_angles.size() > 0 || start || expected_matrices.size() > 0)
               && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        while (quiet_after < 2 * LATENCY && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            quiet_after++;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
        end
        else
        begin
            $display("sent %0d angle words, checked %0d matrices over all quadrants",
                     words_sent, words_seen);
            if (errors == 0)
            begin
                $display("*** PASSED ***");
            end
            else
            begin
                $display("*** FAILED ***");
            end
        end
        $finish;
    end

endmodule
